/* rtl/core/ris_pkg.sv */
// Package: shared types and constants for the record insertion sorter.
`timescale 1ns / 1ps

package ris_pkg;

    // Field widths of one record
    localparam int KEY_W  = 32;
    localparam int FLAG_W = 8;
    localparam int ID_W   = 6;

    // Default store depth
    localparam int MAX_RECORDS_DEF = 32;

    // One stored record
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [FLAG_W-1:0] flag;
        logic [ID_W-1:0]   id;
    } rec_t;

    // Controller states
    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;   // insert the incoming record
        logic drop;   // incoming record does not fit
        logic pop;    // head record transferred, shift the chain down
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic full;      // no free cell left
        logic last_one;  // exactly one record left in the store
    } dp_status_t;

endpackage

/* rtl/core/ris_ifs.sv */
// Interfaces: input record channel and sorted result channel.
`timescale 1ns / 1ps

interface rec_in_if;
    logic                     valid;
    logic                     ready;
    logic signed [31:0]       energy_key;
    logic        [7:0]        conv_flag;
    logic        [5:0]        record_id;
    logic                     last_in;

    modport source (output valid, energy_key, conv_flag, record_id, last_in, input ready);
    modport sink   (input valid, energy_key, conv_flag, record_id, last_in, output ready);
endinterface

interface rec_out_if;
    logic                     valid;
    logic                     ready;
    logic signed [31:0]       sorted_key;
    logic        [7:0]        sorted_flag;
    logic        [5:0]        sorted_id;
    logic                     last_out;
    logic                     overflowed;

    modport source (output valid, sorted_key, sorted_flag, sorted_id, last_out, overflowed,
                    input ready);
    modport sink   (input valid, sorted_key, sorted_flag, sorted_id, last_out, overflowed,
                    output ready);
endinterface

/* rtl/core/ris_ctrl.sv */
// Controller: load/emit state machine of the record insertion sorter.
`timescale 1ns / 1ps

module ris_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_last,
    input  logic               out_ready,
    input  ris_pkg::dp_status_t status,
    output logic               in_ready,
    output logic               out_valid,
    output ris_pkg::dp_cmd_t   cmd
);
    import ris_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_valid && in_last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_ready && status.last_one)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Outputs and datapath commands
    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        cmd       = '0;
        case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid && !status.full;
                cmd.drop = in_valid && status.full;
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
                cmd.pop   = out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

/* rtl/core/ris_dp.sv */
// Datapath: systolic insertion chain of record cells, fill count and overflow bit.
`timescale 1ns / 1ps

module ris_dp
#(
    parameter int MAX_RECORDS = ris_pkg::MAX_RECORDS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  ris_pkg::dp_cmd_t    cmd,
    input  ris_pkg::rec_t       new_rec,
    output ris_pkg::dp_status_t status,
    output ris_pkg::rec_t       head_rec,
    output logic                ovf
);
    import ris_pkg::*;

    localparam int CNT_W = $clog2(MAX_RECORDS + 1);

    rec_t             cell_reg [MAX_RECORDS];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             ovf_reg;
    logic             ovf_next;

    // keep[i]: cell i holds a record that stays ahead of the new one
    logic [MAX_RECORDS-1:0] keep;

    // Per-cell compare, all cells at once
    generate
        for (genvar i = 0; i < MAX_RECORDS; i++)
        begin : g_cmp
            assign keep[i] = (CNT_W'(i) < count_reg) &&
                             !($signed(cell_reg[i].key) > $signed(new_rec.key));
        end
    endgenerate

    // Cell registers: insert shifts the tail up, pop shifts everything down
    generate
        for (genvar i = 0; i < MAX_RECORDS; i++)
        begin : g_cell
            logic take_new;
            logic take_prev;
            rec_t upper;

            if (i == 0)
            begin : g_first
                assign take_new  = !keep[i];
                assign take_prev = 1'b0;
            end
            else
            begin : g_rest
                assign take_new  = !keep[i] && keep[i-1];
                assign take_prev = !keep[i] && !keep[i-1];
            end

            if (i == MAX_RECORDS - 1)
            begin : g_top
                assign upper = cell_reg[i];
            end
            else
            begin : g_mid
                assign upper = cell_reg[i+1];
            end

            always_ff @(posedge clk)
            begin
                if (cmd.load)
                begin
                    if (take_new)
                    begin
                        cell_reg[i] <= new_rec;
                    end
                    else if (take_prev)
                    begin
                        cell_reg[i] <= cell_reg[(i == 0) ? 0 : i-1];
                    end
                end
                else if (cmd.pop)
                begin
                    cell_reg[i] <= upper;
                end
            end
        end
    endgenerate

    // Fill count and overflow next values
    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (cmd.load)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        if (cmd.drop)
        begin
            ovf_next = 1'b1;
        end
        else if (cmd.pop && status.last_one)
        begin
            ovf_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    assign status.full     = (count_reg == CNT_W'(MAX_RECORDS));
    assign status.last_one = (count_reg == CNT_W'(1));
    assign head_rec        = cell_reg[0];
    assign ovf             = ovf_reg;

endmodule

/* rtl/core/record_insertion_sorter.sv */
// Top level of the record insertion sorter.
// Loading: one record transfer per cycle; a record that fits is inserted as it is taken.
// Emission: starts the cycle after the record marked last, one result per cycle while
// the sink is ready; after the final result of a segment the next cycle accepts input again.
// Reset (asynchronous, active low) empties the store and clears the overflow bit.
`timescale 1ns / 1ps

module record_insertion_sorter
#(
    parameter int MAX_RECORDS = ris_pkg::MAX_RECORDS_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    rec_in_if.sink   rec_in,
    rec_out_if.source rec_out
);
    import ris_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    rec_t       new_rec;
    rec_t       head_rec;
    logic       ovf;

    // Pack the incoming record
    assign new_rec.key  = rec_in.energy_key;
    assign new_rec.flag = rec_in.conv_flag;
    assign new_rec.id   = rec_in.record_id;

    ris_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rec_in.valid),
        .in_last   (rec_in.last_in),
        .out_ready (rec_out.ready),
        .status    (status),
        .in_ready  (rec_in.ready),
        .out_valid (rec_out.valid),
        .cmd       (cmd)
    );

    ris_dp #(
        .MAX_RECORDS (MAX_RECORDS)
    ) u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .new_rec  (new_rec),
        .status   (status),
        .head_rec (head_rec),
        .ovf      (ovf)
    );

    // Result fields come straight from the head cell
    assign rec_out.sorted_key  = head_rec.key;
    assign rec_out.sorted_flag = head_rec.flag;
    assign rec_out.sorted_id   = head_rec.id;
    assign rec_out.last_out    = status.last_one;
    assign rec_out.overflowed  = ovf;

`ifndef SYNTH
    // Input and output never open at the same time
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        rec_out.valid |-> !rec_in.ready)
        else $error("input and output both open");

    // The record marked last starts emission in the next cycle
    a_emit_start: assert property (@(posedge clk) disable iff (!rst_n)
        (rec_in.valid && rec_in.ready && rec_in.last_in) |=> rec_out.valid)
        else $error("emission did not start after last record");

    // After the final result transfer the block takes input again
    a_reload: assert property (@(posedge clk) disable iff (!rst_n)
        (rec_out.valid && rec_out.ready && rec_out.last_out) |=>
            (rec_in.ready && !rec_out.valid && !rec_out.overflowed))
        else $error("segment end did not return to loading");

    // Overflow bit holds across the results of a segment
    a_ovf_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rec_out.valid && rec_out.ready && !rec_out.last_out) |=>
            (rec_out.valid && $stable(rec_out.overflowed)))
        else $error("overflow bit changed within a segment");
`endif

endmodule
